[rtl/core/assert_macros.svh]
// assertion helpers, sampled on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lrupr_pkg.sv]
package lrupr_pkg;

  localparam int PAGE_W         = 16;
  localparam int COUNT_W        = 32;
  localparam int CFG_W          = 4;
  localparam int MAX_FRAMES_DEF = 8;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

  // result item: hit, evict_valid, evicted_page, hit_total, fault_total
  localparam int RES_BITS = 1 + 1 + PAGE_W + COUNT_W + COUNT_W;
  localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;
  localparam int IN_W     = ((PAGE_W + 7) / 8) * 8;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

[rtl/core/lrupr_match.sv]
module lrupr_match #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int OCC_W      = $clog2(MAX_FRAMES + 1)
) (
  input  lrupr_pkg::page_t  page,
  input  lrupr_pkg::page_t  entries [MAX_FRAMES],
  input  logic [OCC_W-1:0]  occupancy,
  output logic [MAX_FRAMES-1:0] first,
  output logic              hit
);
  import lrupr_pkg::*;

  logic [MAX_FRAMES-1:0] eq;
  logic [MAX_FRAMES-1:0] below;

  // compare against every resident entry at once
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      eq[k] = (OCC_W'(k) < occupancy) && (entries[k] == page);
    end
  end

  // oldest matching entry wins
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      below[k] = |(eq & ((MAX_FRAMES'(1) << k) - MAX_FRAMES'(1)));
      first[k] = eq[k] & ~below[k];
    end
  end

  assign hit = |eq;

endmodule

[rtl/core/lrupr_frames.sv]
module lrupr_frames #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int OCC_W      = $clog2(MAX_FRAMES + 1)
) (
  input  logic                  clk,
  input  logic                  upd,
  input  lrupr_pkg::page_t      page,
  input  logic                  hit,
  input  logic                  evict,
  input  logic [MAX_FRAMES-1:0] first,
  input  logic [OCC_W-1:0]      occupancy,
  output lrupr_pkg::page_t      entries [MAX_FRAMES]
);
  import lrupr_pkg::*;

  logic [MAX_FRAMES-1:0] shift_en;
  logic [OCC_W-1:0]      tail;
  page_t                 entries_next [MAX_FRAMES];

  // the list stays packed oldest first; the new page lands at the tail
  assign tail = (hit || evict) ? occupancy - OCC_W'(1) : occupancy;

  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      // on a hit everything from the match position onward moves down
      shift_en[k] = hit ? |(first & ((MAX_FRAMES'(1) << (k + 1)) - MAX_FRAMES'(1)))
                        : evict;
      if (OCC_W'(k) == tail) begin
        entries_next[k] = page;
      end else if (shift_en[k] && (k + 1 < MAX_FRAMES)) begin
        entries_next[k] = entries[(k + 1 < MAX_FRAMES) ? k + 1 : k];
      end else begin
        entries_next[k] = entries[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        entries[k] <= entries_next[k];
      end
    end
  end

endmodule

[rtl/core/lru_page_replacement.sv]
// LRU page replacement: one page reference per item, one result item per reference, and one
// item can be taken every clock cycle while m_tready does not hold the output. A reference is
// held in an input register and in the following cycle compared against all MAX_FRAMES
// resident entries in parallel, and its result is registered. Evicted_page is zero when
// nothing is evicted, the hit and fault totals saturate at all ones, and a cfg write of
// frames_in_use (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES) takes effect for the
// next reference; lowering it below the current occupancy drops nothing at once.
`include "assert_macros.svh"

module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,  // frames_in_use
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lrupr_pkg::IN_W-1:0]    s_tdata,    // page
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // hit, evict_valid, evicted_page, hit_total, fault_total, zero pad
  output logic [lrupr_pkg::RES_W-1:0]   m_tdata
);
  import lrupr_pkg::*;

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  logic [CFG_W-1:0]      frames_in_use;
  logic [LIM_W-1:0]      limit;
  logic                  s1_valid;
  page_t                 s1_page;
  logic                  advance;
  logic [OCC_W-1:0]      occupancy;
  logic [OCC_W-1:0]      occupancy_next;
  count_t                hit_count;
  count_t                hit_count_next;
  count_t                fault_count;
  count_t                fault_count_next;
  page_t                 entries [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] first;
  logic                  hit;
  logic                  evict;
  page_t                 victim;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_wen) begin
      frames_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(frames_in_use) > LIM_W'(MAX_FRAMES)) begin
      limit = LIM_W'(MAX_FRAMES);
    end else begin
      limit = LIM_W'(frames_in_use);
    end
  end

  // input stage
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_page <= s_tdata[PAGE_W-1:0];
    end
  end

  lrupr_match #(
    .MAX_FRAMES (MAX_FRAMES),
    .OCC_W      (OCC_W)
  ) u_match (
    .page      (s1_page),
    .entries   (entries),
    .occupancy (occupancy),
    .first     (first),
    .hit       (hit)
  );

  assign evict  = !hit && (occupancy != '0) && (LIM_W'(occupancy) >= limit);
  assign victim = evict ? entries[0] : '0;

  lrupr_frames #(
    .MAX_FRAMES (MAX_FRAMES),
    .OCC_W      (OCC_W)
  ) u_frames (
    .clk       (clk),
    .upd       (advance),
    .page      (s1_page),
    .hit       (hit),
    .evict     (evict),
    .first     (first),
    .occupancy (occupancy),
    .entries   (entries)
  );

  always_comb begin
    occupancy_next   = (hit || evict) ? occupancy : occupancy + OCC_W'(1);
    hit_count_next   = hit_count;
    fault_count_next = fault_count;
    if (hit) begin
      if (hit_count != '1) begin
        hit_count_next = hit_count + COUNT_W'(1);
      end
    end else if (fault_count != '1) begin
      fault_count_next = fault_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      hit_count   <= '0;
      fault_count <= '0;
    end else if (advance) begin
      occupancy   <= occupancy_next;
      hit_count   <= hit_count_next;
      fault_count <= fault_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= RES_W'({fault_count_next, hit_count_next, victim, evict, hit});
    end
  end

  `ASSERT_ALWAYS(a_first_onehot, $onehot0(first), "more than one match position selected")
  `ASSERT_ALWAYS(a_occ_range, occupancy <= OCC_W'(MAX_FRAMES), "occupancy above frame count")
  `ASSERT_NEXT(a_hit_keeps_occ, advance && hit, $stable(occupancy), "hit changed occupancy")
  `ASSERT_IMPLIES(a_hit_no_evict, m_tvalid, !(m_tdata[0] && m_tdata[1]),
                  "result shows both hit and eviction")
  `ASSERT_IMPLIES(a_victim_zero, m_tvalid && !m_tdata[1], m_tdata[PAGE_W+1:2] == '0,
                  "evicted page nonzero without eviction")

endmodule

[dv/lru_page_replacement_tb.sv]
module lru_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam int FRAME_CNT = MAX_FRAMES_DEF;

  // lowest bit first: hit, evict_valid, evicted_page, hit_total, fault_total
  typedef struct packed {
    count_t fault_total;
    count_t hit_total;
    page_t  evicted_page;
    logic   evict_valid;
    logic   hit;
  } lru_result_t;

  class lru_scoreboard;
    page_t             resident[FRAME_CNT];
    int unsigned       fill;
    count_t            hits;
    count_t            faults;
    logic [CFG_W-1:0]  frames_cfg;
    lru_result_t       expected_q[$];
    int unsigned       failures;

    function new();
      fill       = 0;
      hits       = '0;
      faults     = '0;
      frames_cfg = FRAMES_RESET;
      failures   = 0;
      foreach (resident[i]) resident[i] = '0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] v);
      frames_cfg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // remove one entry, newer entries slide toward the oldest end
    function void remove_at(int unsigned pos);
      for (int unsigned k = pos; k + 1 < fill; k++) resident[k] = resident[k + 1];
      fill--;
    endfunction

    function void note_page(page_t p);
      lru_result_t r;
      int unsigned limit;
      int unsigned pos;
      bit          found;
      r     = '0;
      found = 0;
      pos   = 0;
      if (frames_cfg == 0) limit = 1;
      else if (frames_cfg > FRAME_CNT) limit = FRAME_CNT;
      else limit = frames_cfg;
      for (int unsigned k = 0; k < fill; k++) begin
        if (!found && resident[k] == p) begin
          found = 1;
          pos   = k;
        end
      end
      if (found) begin
        if (hits != '1) hits++;
        remove_at(pos);
      end else begin
        if (faults != '1) faults++;
        // full list or limit lowered below occupancy: oldest page goes
        if (fill >= limit && fill > 0) begin
          r.evict_valid  = 1'b1;
          r.evicted_page = resident[0];
          remove_at(0);
        end
      end
      if (fill < FRAME_CNT) begin
        resident[fill] = p;
        fill++;
      end
      r.hit         = found;
      r.hit_total   = hits;
      r.fault_total = faults;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [RES_W-1:0] data);
      lru_result_t got;
      lru_result_t want;
      got = data[RES_BITS-1:0];
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result item %h", data);
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit || got.evict_valid !== want.evict_valid ||
          got.evicted_page !== want.evicted_page || got.hit_total !== want.hit_total ||
          got.fault_total !== want.fault_total) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: hit %b/%b evict %b/%b page %h/%h hits %0d/%0d faults %0d/%0d",
                   want.hit, got.hit, want.evict_valid, got.evict_valid,
                   want.evicted_page, got.evicted_page, want.hit_total, got.hit_total,
                   want.fault_total, got.fault_total);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [RES_W-1:0]  m_tdata;

  lru_scoreboard sb;
  bit            idle_on;
  page_t         pool[$];

  lru_page_replacement #(.MAX_FRAMES(FRAME_CNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    idle_on   = 1'b1;
    sb        = new();
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver side: ready drops in random bursts while idling is on
  initial begin
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 6) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_page(input page_t p);
    s_tdata  = p;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_page(p);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_wen   = 1'b1;
    @(negedge clk);
    cfg_wen = 1'b0;
    sb.set_frames(v);
  endtask

  // working set of the frame count or a little larger, so hits and misses mix
  task automatic refill_pool(input int unsigned sz);
    pool.delete();
    for (int unsigned i = 0; i < sz; i++) begin
      case ($urandom_range(0, 9))
        0:       pool.insert(pool.size(), 16'h0000);
        1:       pool.insert(pool.size(), 16'hffff);
        default: pool.insert(pool.size(), page_t'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg[9];
    int unsigned      lim;
    page_t            p;
    phase_cfg = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd2, 4'd9, 4'd5, 4'd8};
    #0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset frame count: fill, hit oldest, evictions, hit oldest, hit newest, hit middle, evictions
    send_page(16'h0000);
    send_page(16'hffff);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0000);
    send_page(16'h0003);
    send_page(16'hffff);
    send_page(16'h0002);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'haaaa);
    send_page(16'h5555);
    // zero acts as one frame, and occupancy is above it
    write_frames(4'd0);
    send_page(16'h5555);
    send_page(16'h1234);
    send_page(16'h1234);
    // above the built count acts as the built count
    write_frames(4'd15);
    for (int i = 0; i < 9; i++) send_page(page_t'(16'h0100 + i));
    send_page(16'h0101);
    send_page(16'h0100);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph >= 6) phase_cfg[ph] = ($urandom_range(0, 1) == 0) ? phase_cfg[ph]
                                                                : 4'($urandom_range(0, 15));
      write_frames(phase_cfg[ph]);
      idle_on = (ph != 8) && (ph % 3 != 2 || $urandom_range(0, 1) == 0);
      lim = (phase_cfg[ph] == 0) ? 1 : (phase_cfg[ph] > FRAME_CNT ? FRAME_CNT : phase_cfg[ph]);
      refill_pool(lim + $urandom_range(0, 4));
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 99) < 85) p = pool[$urandom_range(0, pool.size() - 1)];
        else p = page_t'($urandom);
        sender_gap();
        send_page(p);
      end
    end

    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_match.sv
rtl/core/lrupr_frames.sv
rtl/core/lru_page_replacement.sv
dv/lru_page_replacement_tb.sv
